// File: src/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants for the minimum radix converter
// Digit decode, status codes and the value limit used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

   // Default depth of the digit store
   localparam int MAX_DIGITS_DEF = 64;

   // Widths fixed by the result fields
   localparam int DIGIT_W  = 6;
   localparam int RADIX_W  = 6;
   localparam int VALUE_W  = 31;
   localparam int STATUS_W = 2;

   // Largest value that still reports ok
   localparam logic [VALUE_W-1:0] VALUE_LIMIT = {VALUE_W{1'b1}};

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // Decoded character
   typedef struct packed {
      logic               ok;
      logic [DIGIT_W-1:0] digit;
   } digit_type;

   // Control from the sequencer to the accumulator
   typedef struct packed {
      logic clear;
      logic step;
   } mac_ctrl_type;

   // Map an ASCII byte to a digit 0..35; ok is low for anything else
   function automatic digit_type decode_char(input logic [7:0] code);
      digit_type res;
      res.ok    = 1'b0;
      res.digit = '0;
      if (code >= 8'h30 && code <= 8'h39) begin
         res.ok    = 1'b1;
         res.digit = DIGIT_W'(code - 8'h30);
      end else if (code >= 8'h41 && code <= 8'h5A) begin
         res.ok    = 1'b1;
         res.digit = DIGIT_W'(code - 8'h41 + 8'd10);
      end else if (code >= 8'h61 && code <= 8'h7A) begin
         res.ok    = 1'b1;
         res.digit = DIGIT_W'(code - 8'h61 + 8'd10);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: src/mrc_ram.sv
// ----------------------------------------------------------------------------
// mrc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/mrc_mac.sv
// ----------------------------------------------------------------------------
// mrc_mac: multiply-accumulate with exact overflow detection
// Folds one digit per step into acc = acc * radix + digit, sticky overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_mac (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mrc_pkg::mac_ctrl_type             ctrl,
   input  wire logic [mrc_pkg::RADIX_W-1:0]       radix,
   input  wire logic [mrc_pkg::DIGIT_W-1:0]       digit,
   output logic      [mrc_pkg::VALUE_W-1:0]       acc,
   output logic                                   overflow
);

   localparam int PROD_W = mrc_pkg::VALUE_W + mrc_pkg::RADIX_W;
   localparam int SUM_W  = PROD_W + 1;

   logic [mrc_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic                        ovf_ff, ovf_in;
   logic [PROD_W-1:0]           prod;
   logic [SUM_W-1:0]            sum;

   // Next accumulator value and limit check
   always_comb begin
      prod   = PROD_W'(acc_ff) * PROD_W'(radix);
      sum    = SUM_W'(prod) + SUM_W'(digit);
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      priority if (ctrl.clear) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (ctrl.step && !ovf_ff) begin
         if (sum > SUM_W'(mrc_pkg::VALUE_LIMIT)) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = sum[mrc_pkg::VALUE_W-1:0];
         end
      end
   end

   // Hold accumulator; overflow flag is control state
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (reset) begin
         ovf_ff <= 1'b0;
      end else begin
         ovf_ff <= ovf_in;
      end
   end

   assign acc      = acc_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

// File: src/min_radix_number_converter.sv
// ----------------------------------------------------------------------------
// min_radix_number_converter: minimum radix detection and base conversion
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one ASCII character per word, with req_last_char
//   set on the final character of a token. Characters are taken one per
//   cycle; digits are 0-9 and letters of either case (10..35). Leading zeros
//   are not stored. After the final character the block stops taking words,
//   reads the stored digits back from the digit RAM one per cycle and folds
//   them into the value through the multiply-accumulate unit.
//   The rsp channel gives one word per token: status, smallest radix and
//   value. The response word is loaded once every stored digit has been
//   read back through the RAM read port, one digit a cycle, and folded into
//   the value. The next token starts as soon as the response register is
//   loaded.
//   A stalled response is held in the output register; the block keeps
//   taking characters of the next token meanwhile and waits only when that
//   token's own response is ready and the register is still full.
//   Reset clears the token state and the response valid; the digit RAM is
//   not cleared, since only entries written by the current token are read.
// ----------------------------------------------------------------------------
`default_nettype none

module min_radix_number_converter #(
   parameter int MAX_DIGITS = mrc_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_char_code,
   input  wire logic                                req_last_char,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [mrc_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [mrc_pkg::RADIX_W-1:0]         rsp_min_radix,
   output logic      [mrc_pkg::VALUE_W-1:0]         rsp_value
);

   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CONV,
      ST_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [mrc_pkg::RADIX_W-1:0]   max_radix_ff, max_radix_in;
   logic                          bad_ff, bad_in;
   logic                          overrun_ff, overrun_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic                          data_vld_ff, data_vld_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mrc_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [mrc_pkg::RADIX_W-1:0]   rsp_radix_ff, rsp_radix_in;
   logic [mrc_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;

   mrc_pkg::digit_type            dec;
   mrc_pkg::mac_ctrl_type         mac_ctrl;
   logic                          accept;
   logic                          store_full;
   logic                          wr_en;
   logic                          rd_en;
   logic [mrc_pkg::DIGIT_W-1:0]   rd_data;
   logic [mrc_pkg::VALUE_W-1:0]   acc;
   logic                          acc_ovf;
   logic [mrc_pkg::RADIX_W-1:0]   digit_radix;

   // Input handshake and character decode
   assign req_stall   = (state_ff != ST_LOAD);
   assign accept      = req_valid && !req_stall;
   assign dec         = mrc_pkg::decode_char(req_char_code);
   assign store_full  = (count_ff == CNT_W'(MAX_DIGITS));
   assign digit_radix = dec.digit + mrc_pkg::RADIX_W'(1);
   assign wr_en       = accept && dec.ok && (dec.digit != '0 || count_ff != '0)
                        && !store_full;
   assign rd_en       = (state_ff == ST_CONV) && (idx_ff != count_ff);

   // Sequencer: load characters, walk the store, deliver the result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      max_radix_in  = max_radix_ff;
      bad_in        = bad_ff;
      overrun_in    = overrun_ff;
      idx_in        = idx_ff;
      data_vld_in   = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_radix_in  = rsp_radix_ff;
      rsp_value_in  = rsp_value_ff;
      mac_ctrl      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (!dec.ok) begin
                  bad_in = 1'b1;
               end else begin
                  if (digit_radix > max_radix_ff) begin
                     max_radix_in = digit_radix;
                  end
                  if (dec.digit != '0 || count_ff != '0) begin
                     if (store_full) begin
                        overrun_in = 1'b1;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
               end
               if (req_last_char) begin
                  state_in      = ST_CONV;
                  idx_in        = '0;
                  mac_ctrl.clear = 1'b1;
               end
            end
         end
         ST_CONV: begin
            // Issue one read a cycle; fold the digit that returns
            data_vld_in   = rd_en;
            mac_ctrl.step = data_vld_ff;
            if (rd_en) begin
               idx_in = idx_ff + CNT_W'(1);
            end else if (!data_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               priority if (bad_ff) begin
                  rsp_status_in = mrc_pkg::STATUS_BAD_CHAR;
                  rsp_radix_in  = '0;
                  rsp_value_in  = '0;
               end else if (overrun_ff || acc_ovf) begin
                  rsp_status_in = mrc_pkg::STATUS_OVERFLOW;
                  rsp_radix_in  = max_radix_ff;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = mrc_pkg::STATUS_OK;
                  rsp_radix_in  = max_radix_ff;
                  rsp_value_in  = acc;
               end
               // Drop the token state for the next token
               count_in     = '0;
               max_radix_in = '0;
               bad_in       = 1'b0;
               overrun_in   = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_radix_ff  <= rsp_radix_in;
      rsp_value_ff  <= rsp_value_in;
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         max_radix_ff <= '0;
         bad_ff       <= 1'b0;
         overrun_ff   <= 1'b0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_radix_ff <= max_radix_in;
         bad_ff       <= bad_in;
         overrun_ff   <= overrun_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Digit store
   mrc_ram #(
      .WIDTH(mrc_pkg::DIGIT_W),
      .DEPTH(MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (dec.digit),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Value accumulator
   mrc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .radix    (max_radix_ff),
      .digit    (rd_data),
      .acc      (acc),
      .overflow (acc_ovf)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_min_radix = rsp_radix_ff;
   assign rsp_value     = rsp_value_ff;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for min_radix_number_converter
// Streams ASCII tokens one character per word and checks each token's
// status, smallest radix and value against a built-in converter, under
// three idle mixes, long response hold-offs and drain pauses.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int STORE_DEPTH  = mrc_pkg::MAX_DIGITS_DEF;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = STORE_DEPTH + 16;
   localparam int CHOKE_CYCLES = 400;
   localparam int TARGET_CHARS = 1000;

   typedef logic [7:0] char_list_type [$];

   // One character word waiting to be sent
   typedef struct {
      logic [7:0]  code;
      logic        last;
      int          phase;
      int          seq;
      bit          choke;
      bit          drain;
   } char_word_type;

   // One converted token
   typedef struct {
      mrc_pkg::status_type                 status;
      logic [mrc_pkg::RADIX_W-1:0]         radix;
      logic [mrc_pkg::VALUE_W-1:0]         value;
   } token_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [7:0]                   req_char_code = '0;
   logic                         req_last_char = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [mrc_pkg::STATUS_W-1:0] rsp_status;
   logic [mrc_pkg::RADIX_W-1:0]  rsp_min_radix;
   logic [mrc_pkg::VALUE_W-1:0]  rsp_value;

   char_word_type    char_words [$];
   token_result_type token_results_q [$];

   // Converter state for the token in flight
   logic [mrc_pkg::DIGIT_W-1:0] tok_digits [STORE_DEPTH];
   int                          tok_len = 0;
   logic [mrc_pkg::RADIX_W-1:0] tok_radix = '0;
   bit                          tok_bad = 1'b0;
   bit                          tok_overrun = 1'b0;

   int   cycle_count = 0;
   int   mismatches = 0;
   int   chars_taken = 0;
   int   n_ok = 0;
   int   n_bad = 0;
   int   n_ovf = 0;
   int   n_queued = 0;
   int   offered_seq = -1;
   int   offered_phase = 0;
   int   choke_left = 0;
   bit   choke_go = 1'b0;
   bit   fire;
   bit   mark_choke = 1'b0;
   bit   mark_drain = 1'b0;
   token_result_type want;

   min_radix_number_converter #(
      .MAX_DIGITS(STORE_DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_min_radix (rsp_min_radix),
      .rsp_value     (rsp_value)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Digit value of a byte, -1 when it is neither digit nor letter
   function automatic int digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   // Character for a digit, letters in a random case
   function automatic logic [7:0] digit_char(input int d);
      if (d < 10) return 8'(int'("0") + d);
      if ($urandom_range(1) == 0) return 8'(int'("A") + d - 10);
      return 8'(int'("a") + d - 10);
   endfunction

   // Random byte that is neither digit nor letter
   function automatic logic [7:0] stray_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (digit_of(c) >= 0) c = 8'($urandom_range(255));
      return c;
   endfunction

   // Fold one accepted character into the token; queue the result on the last
   task automatic convert_char(input logic [7:0] c, input logic last);
      int               d;
      int               i;
      logic [63:0]      acc;
      token_result_type res;
      d = digit_of(c);
      if (d < 0) begin
         tok_bad = 1'b1;
      end else begin
         if (d + 1 > int'(tok_radix)) tok_radix = mrc_pkg::RADIX_W'(d + 1);
         // skip leading zeros, drop digits past the store
         if (d != 0 || tok_len != 0) begin
            if (tok_len < STORE_DEPTH) begin
               tok_digits[tok_len] = mrc_pkg::DIGIT_W'(d);
               tok_len++;
            end else begin
               tok_overrun = 1'b1;
            end
         end
      end
      if (last) begin
         res.status = mrc_pkg::STATUS_OK;
         res.radix  = tok_radix;
         res.value  = '0;
         if (tok_bad) begin
            res.status = mrc_pkg::STATUS_BAD_CHAR;
            res.radix  = '0;
         end else if (tok_overrun) begin
            res.status = mrc_pkg::STATUS_OVERFLOW;
         end else begin
            acc = '0;
            i = 0;
            while (i < tok_len && res.status == mrc_pkg::STATUS_OK) begin
               acc = acc * tok_radix + tok_digits[i];
               if (acc > 64'(mrc_pkg::VALUE_LIMIT)) res.status = mrc_pkg::STATUS_OVERFLOW;
               i++;
            end
            if (res.status == mrc_pkg::STATUS_OK) res.value = acc[mrc_pkg::VALUE_W-1:0];
         end
         token_results_q.push_back(res);
         tok_len     = 0;
         tok_radix   = '0;
         tok_bad     = 1'b0;
         tok_overrun = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      $display("MISMATCH at %0t: %s got %0d, want %0d", $time, what, got, exp_val);
      mismatches++;
   endtask

   // Append one word; the first word after a mark carries it
   task automatic queue_word(input logic [7:0] code, input logic last);
      char_word_type w;
      w.code  = code;
      w.last  = last;
      w.phase = (n_queued < 330) ? 0 : (n_queued < 660) ? 1 : 2;
      w.seq   = n_queued;
      w.choke = mark_choke;
      w.drain = mark_drain;
      mark_choke = 1'b0;
      mark_drain = 1'b0;
      char_words.push_back(w);
      n_queued++;
   endtask

   task automatic queue_token(input char_list_type t);
      for (int i = 0; i < t.size(); i++) queue_word(t[i], i == t.size() - 1);
   endtask

   task automatic queue_text(input string s);
      char_list_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      queue_token(t);
   endtask

   // Build one random token, mostly well-formed with random content
   task automatic make_random_token();
      char_list_type t;
      int            kind;
      int            r;
      int            len;
      logic [63:0]   span;
      kind = $urandom_range(99);
      r    = $urandom_range(2, 36);
      if (kind < 45) begin
         // plain digits below a random radix, some leading zeros
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) t.push_back("0");
         len = $urandom_range(1, 7);
         repeat (len) t.push_back(digit_char($urandom_range(r - 1)));
      end else if (kind < 65) begin
         // length right at the value limit for this radix
         len  = 0;
         span = 1;
         while (span <= 64'(mrc_pkg::VALUE_LIMIT)) begin
            span = span * r;
            len++;
         end
         len = len - 1 + $urandom_range(1);
         t.push_back(digit_char($urandom_range(1, r - 1)));
         for (int i = 1; i < len; i++) begin
            t.push_back(digit_char(($urandom_range(1) == 1) ? r - 1 : $urandom_range(r - 1)));
         end
      end else if (kind < 75) begin
         // raw bytes
         repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
      end else if (kind < 85) begin
         // well-formed token with one stray byte
         len = $urandom_range(2, 9);
         repeat (len) t.push_back(digit_char($urandom_range(r - 1)));
         t[$urandom_range(len - 1)] = stray_char();
      end else if (kind < 91) begin
         repeat ($urandom_range(1, 5)) t.push_back("0");
      end else if (kind < 97) begin
         // binary ones around 31 bits
         repeat ($urandom_range(2)) t.push_back("0");
         repeat ($urandom_range(30, 33)) t.push_back("1");
      end else begin
         // significant digits around the store depth
         repeat ($urandom_range(2)) t.push_back("0");
         t.push_back("1");
         repeat ($urandom_range(STORE_DEPTH - 3, STORE_DEPTH + 1)) begin
            t.push_back(digit_char($urandom_range(1)));
         end
      end
      queue_token(t);
   endtask

   // Offer words; predict each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         choke_go  <= 1'b0;
      end else begin
         fire = 1'b0;
         if (req_valid && !req_stall) begin
            convert_char(req_char_code, req_last_char);
            chars_taken++;
            void'(char_words.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (char_words.size() != 0 && char_words[0].drain &&
                      char_words[0].seq != offered_seq && token_results_q.size() != 0) begin
            req_valid <= 1'b0;
         end else if (char_words.size() != 0 &&
                      $urandom_range(99) >= ((char_words[0].phase == 0) ? 10 :
                                             (char_words[0].phase == 1) ? 83 : 0)) begin
            req_valid     <= 1'b1;
            req_char_code <= char_words[0].code;
            req_last_char <= char_words[0].last;
            offered_phase <= char_words[0].phase;
            fire = char_words[0].choke && char_words[0].seq != offered_seq;
            offered_seq = char_words[0].seq;
         end else begin
            req_valid <= 1'b0;
         end
         choke_go <= fire;
      end
   end

   // Check each taken result; stall at random or for a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (token_results_q.size() == 0) begin
               report_mismatch("result with no token pending, value", rsp_value, 0);
            end else begin
               want = token_results_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_min_radix !== want.radix)
                  report_mismatch("min_radix", rsp_min_radix, want.radix);
               if (rsp_value !== want.value)
                  report_mismatch("value", rsp_value, want.value);
               if (want.status == mrc_pkg::STATUS_OK) n_ok++;
               else if (want.status == mrc_pkg::STATUS_BAD_CHAR) n_bad++;
               else n_ovf++;
            end
         end
         if (choke_go) choke_left = CHOKE_CYCLES;
         if (choke_left != 0) begin
            choke_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < ((offered_phase == 0) ? 83 :
                                                (offered_phase == 1) ? 10 : 0));
         end
      end
   end

   // Fill the word queue, release reset, wait for the last result
   initial begin
      int next_choke;
      int next_drain;
      next_choke = 200;
      next_drain = 450;

      // extremes, every class of character and each special case
      queue_text("0");
      queue_text("007");
      queue_text("Zz");
      queue_text("zik0zj");
      queue_text("ZIK0ZK");
      queue_word("1", 1'b0);
      queue_word(8'hFF, 1'b1);
      queue_word(8'h00, 1'b1);
      queue_text("@[`{:");

      while (n_queued < TARGET_CHARS) begin
         if (n_queued >= next_choke) begin
            mark_choke = 1'b1;
            next_choke += 500;
         end
         if (n_queued >= next_drain) begin
            mark_drain = 1'b1;
            next_drain += 450;
         end
         make_random_token();
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (char_words.size() != 0 || token_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d characters; tokens checked: %0d ok, %0d bad character, %0d overflow",
               chars_taken, n_ok, n_bad, n_ovf);
      $display("Covered three idle mixes, long response hold-offs and drain pauses");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: min_radix_number_converter.f
src/mrc_pkg.sv
src/mrc_ram.sv
src/mrc_mac.sv
src/min_radix_number_converter.sv
tb/tb_top.sv
